>>> design/great_circle_initial_bearing_macros.svh
// Assertion macros for the great-circle bearing block.
// Used by great_circle_initial_bearing.sv; no other dependencies.
`ifndef GREAT_CIRCLE_INITIAL_BEARING_MACROS_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GCIB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GCIB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gcib_pkg.sv
// Package for the great-circle bearing block: Q30 constants, formats, CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps

package gcib_pkg;

    // defaults for the top-level parameters
    localparam int ANGLE_FRAC_BITS_DEF = 29;
    localparam int CORDIC_STEPS_DEF    = 24;

    // internal angle format is Q30
    localparam int QF = 30;
    // rotation datapath width and vectoring datapath width
    localparam int ZW = 34;
    localparam int VW = 36;

    localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [ZW-1:0] INV_GAIN_Q30 = 34'sd652032874;

    // radians to degrees: reciprocal of pi scaled by 180 * 2^DEG_SHIFT, rounded up
    localparam int          DEG_SHIFT = 40;
    localparam int          DEG_RW    = 17;
    localparam logic [63:0] DEG_RECIP =
        ((64'd180 << DEG_SHIFT) + 64'd3373259426 - 64'd1) / 64'd3373259426;
    localparam int          DEG_W     = 11;
    localparam logic signed [DEG_W-1:0] FULL_TURN = 11'sd360;

    // atan(2^-i) in Q30, truncated up to index 26 and rounded from 27 to 30; zero past index 30
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/great_circle_initial_bearing.sv
// Great-circle initial bearing: fully pipelined CORDIC sin/cos, products, atan2, degrees.
// Depends on gcib_pkg and great_circle_initial_bearing_macros.svh.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  input     | start & !busy        | i_from_latitude/longitude, i_to_latitude/longitude
//  result    | o_valid, one cycle   | o_bearing_degrees
//
// A result passes ANGLE_REDUCE = max(0, 30 - ANGLE_FRAC_BITS) + 1 restoring steps of
// the modulo-2*pi reduction and then the two chains of CORDIC stages, which dominate
// its delay. One transfer is taken every cycle.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// Reset clears only the valid bits; data registers load every cycle.
`timescale 1ns / 1ps
`include "great_circle_initial_bearing_macros.svh"

module great_circle_initial_bearing
    import gcib_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_from_latitude,
    input  logic signed [31:0] i_from_longitude,
    input  logic signed [30:0] i_to_latitude,
    input  logic signed [31:0] i_to_longitude,
    output logic               o_valid,
    output logic [8:0]         o_bearing_degrees
);

    localparam int UP    = (ANGLE_FRAC_BITS < QF) ? QF - ANGLE_FRAC_BITS : 0;
    localparam int DN    = (ANGLE_FRAC_BITS > QF) ? ANGLE_FRAC_BITS - QF : 0;
    localparam int AW    = 34 + UP;
    localparam int NR    = UP + 1;
    localparam int N     = CORDIC_STEPS;
    localparam int IX_W2 = NR + 3;
    localparam int IX_D2 = NR + 2 * N + 9;
    localparam int DEPTH = NR + 2 * N + 11;
    localparam int PW    = VW + DEG_RW;
    localparam int RW    = 48;

    localparam logic signed [AW-1:0] PI_A     = AW'(PI_Q30);
    localparam logic signed [AW-1:0] TWO_PI_A = PI_A <<< 1;

    // valid bits, one per stage
    logic [DEPTH-1:0] r_vld;

    // input conversion and the reduction chain
    logic signed [AW-1:0] n_lat1, n_lat2, n_lon1, n_lon2;
    logic signed [AW-1:0] x_lat1, x_lat2, x_lon1, x_lon2;
    logic signed [AW-1:0] r_ang [3];
    logic [AW-1:0]        r_mag [0:NR][3];
    logic                 r_sgn [0:NR][3];
    logic signed [ZW-1:0] r_wr  [3];

    // rotation CORDIC lanes: 0 = from latitude, 1 = to latitude, 2 = longitude delta
    logic signed [ZW-1:0] r_rx [0:N][3];
    logic signed [ZW-1:0] r_ry [0:N][3];
    logic signed [ZW-1:0] r_rz [0:N][3];
    logic                 r_rneg [0:N][3];
    logic signed [ZW-1:0] r_sin [3];
    logic signed [ZW-1:0] r_cos [3];

    // products
    logic signed [2*ZW-1:0] n_py, n_pt, n_pp, n_pq;
    logic signed [ZW-1:0]   r_y1, r_t1, r_p1, r_cd1;
    logic signed [VW-1:0]   r_mx, r_my;

    // vectoring CORDIC
    logic signed [VW-1:0] r_vx [0:N];
    logic signed [VW-1:0] r_vy [0:N];
    logic signed [VW-1:0] r_vz [0:N];
    logic                 r_vzero [0:N];

    // degree conversion
    logic signed [PW-1:0]    r_prod;
    logic signed [VW-1:0]    r_dz;
    logic                    r_dzero1, r_dzero2;
    logic signed [9:0]       n_d;
    logic signed [RW-1:0]    n_rem;
    logic signed [9:0]       r_d;
    logic signed [RW-1:0]    r_rem;
    logic signed [DEG_W-1:0] n_deg, n_wrap;
    logic [8:0]              r_bearing;

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start & ~busy};
        end
    end

    // bring inputs to Q30 and form the longitude delta
    assign x_lat1 = AW'(i_from_latitude);
    assign x_lat2 = AW'(i_to_latitude);
    assign x_lon1 = AW'(i_from_longitude);
    assign x_lon2 = AW'(i_to_longitude);
    assign n_lat1 = (x_lat1 <<< UP) >>> DN;
    assign n_lat2 = (x_lat2 <<< UP) >>> DN;
    assign n_lon1 = (x_lon1 <<< UP) >>> DN;
    assign n_lon2 = (x_lon2 <<< UP) >>> DN;

    always_ff @(posedge i_clk) begin
        r_ang[0] <= n_lat1;
        r_ang[1] <= n_lat2;
        r_ang[2] <= n_lon2 - n_lon1;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [AW-1:0] n_s, n_w;
        logic signed [ZW-1:0] n_f;
        logic                 n_neg;

        // split sign and magnitude
        always_ff @(posedge i_clk) begin
            r_sgn[0][l] <= r_ang[l][AW-1];
            r_mag[0][l] <= r_ang[l][AW-1] ? $unsigned(-r_ang[l]) : $unsigned(r_ang[l]);
        end

        // reduce the magnitude modulo 2*pi, one restoring step per stage
        for (genvar j = 1; j <= NR; j++) begin : g_red
            localparam logic [AW-1:0] STEP = $unsigned(TWO_PI_A) << (NR - j);
            always_ff @(posedge i_clk) begin
                r_sgn[j][l] <= r_sgn[j-1][l];
                r_mag[j][l] <= (r_mag[j-1][l] >= STEP) ? r_mag[j-1][l] - STEP
                                                       : r_mag[j-1][l];
            end
        end

        // restore sign and wrap into [-pi, pi)
        always_comb begin
            n_s = r_sgn[NR][l] ? -$signed(r_mag[NR][l]) : $signed(r_mag[NR][l]);
            n_w = n_s;
            if (n_s >= PI_A) begin
                n_w = n_s - TWO_PI_A;
            end else if (n_s < -PI_A) begin
                n_w = n_s + TWO_PI_A;
            end
        end

        always_ff @(posedge i_clk) begin
            r_wr[l] <= ZW'(n_w);
        end

        // fold into [-pi/2, pi/2] and seed the rotation
        always_comb begin
            n_f   = r_wr[l];
            n_neg = 1'b0;
            if (r_wr[l] > HALF_PI_Q30) begin
                n_f   = r_wr[l] - PI_Q30;
                n_neg = 1'b1;
            end else if (r_wr[l] < -HALF_PI_Q30) begin
                n_f   = r_wr[l] + PI_Q30;
                n_neg = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rx[0][l]   <= INV_GAIN_Q30;
            r_ry[0][l]   <= '0;
            r_rz[0][l]   <= n_f;
            r_rneg[0][l] <= n_neg;
        end

        // rotation stages
        for (genvar i = 0; i < N; i++) begin : g_rot
            localparam logic signed [ZW-1:0] AT = $signed(ZW'(atan_q30(i)));
            logic signed [ZW-1:0] n_dx, n_dy;
            assign n_dx = r_ry[i][l] >>> i;
            assign n_dy = r_rx[i][l] >>> i;
            always_ff @(posedge i_clk) begin
                r_rneg[i+1][l] <= r_rneg[i][l];
                if (!r_rz[i][l][ZW-1]) begin
                    r_rx[i+1][l] <= r_rx[i][l] - n_dx;
                    r_ry[i+1][l] <= r_ry[i][l] + n_dy;
                    r_rz[i+1][l] <= r_rz[i][l] - AT;
                end else begin
                    r_rx[i+1][l] <= r_rx[i][l] + n_dx;
                    r_ry[i+1][l] <= r_ry[i][l] - n_dy;
                    r_rz[i+1][l] <= r_rz[i][l] + AT;
                end
            end
        end

        // undo the fold
        always_ff @(posedge i_clk) begin
            r_sin[l] <= r_rneg[N][l] ? -r_ry[N][l] : r_ry[N][l];
            r_cos[l] <= r_rneg[N][l] ? -r_rx[N][l] : r_rx[N][l];
        end
    end

    // first products, each floored back to Q30
    assign n_py = r_sin[2] * r_cos[1];
    assign n_pt = r_sin[0] * r_cos[1];
    assign n_pp = r_cos[0] * r_sin[1];

    always_ff @(posedge i_clk) begin
        r_y1  <= ZW'(n_py >>> QF);
        r_t1  <= ZW'(n_pt >>> QF);
        r_p1  <= ZW'(n_pp >>> QF);
        r_cd1 <= r_cos[2];
    end

    // second product and the x difference
    assign n_pq = r_t1 * r_cd1;

    always_ff @(posedge i_clk) begin
        r_my <= VW'(r_y1);
        r_mx <= VW'(r_p1) - VW'(ZW'(n_pq >>> QF));
    end

    // detect the zero vector and pre-rotate the left half-plane
    always_ff @(posedge i_clk) begin
        r_vzero[0] <= (r_mx == '0) && (r_my == '0);
        if (r_mx[VW-1]) begin
            if (!r_my[VW-1]) begin
                r_vx[0] <= r_my;
                r_vy[0] <= -r_mx;
                r_vz[0] <= VW'(HALF_PI_Q30);
            end else begin
                r_vx[0] <= -r_my;
                r_vy[0] <= r_mx;
                r_vz[0] <= -VW'(HALF_PI_Q30);
            end
        end else begin
            r_vx[0] <= r_mx;
            r_vy[0] <= r_my;
            r_vz[0] <= '0;
        end
    end

    // vectoring stages
    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic signed [VW-1:0] AT = $signed(VW'(atan_q30(i)));
        logic signed [VW-1:0] n_dx, n_dy;
        assign n_dx = r_vy[i] >>> i;
        assign n_dy = r_vx[i] >>> i;
        always_ff @(posedge i_clk) begin
            r_vzero[i+1] <= r_vzero[i];
            if (!r_vy[i][VW-1]) begin
                r_vx[i+1] <= r_vx[i] + n_dx;
                r_vy[i+1] <= r_vy[i] - n_dy;
                r_vz[i+1] <= r_vz[i] + AT;
            end else begin
                r_vx[i+1] <= r_vx[i] - n_dx;
                r_vy[i+1] <= r_vy[i] + n_dy;
                r_vz[i+1] <= r_vz[i] - AT;
            end
        end
    end

    // estimate degrees by the scaled reciprocal of pi
    always_ff @(posedge i_clk) begin
        r_prod   <= PW'(r_vz[N]) * PW'($signed({1'b0, DEG_RECIP[DEG_RW-2:0]}));
        r_dz     <= r_vz[N];
        r_dzero1 <= r_vzero[N];
    end

    // remainder of the estimate
    assign n_d   = r_prod[DEG_SHIFT+9:DEG_SHIFT];
    assign n_rem = RW'(r_dz) * RW'(9'sd180) - RW'(n_d) * RW'(PI_Q30);

    always_ff @(posedge i_clk) begin
        r_d      <= n_d;
        r_rem    <= n_rem;
        r_dzero2 <= r_dzero1;
    end

    // correct the floor and wrap into 0..359
    always_comb begin
        n_deg = DEG_W'(r_d);
        if (r_rem < 0) begin
            n_deg = DEG_W'(r_d) - DEG_W'(1);
        end else if (r_rem >= RW'(PI_Q30)) begin
            n_deg = DEG_W'(r_d) + DEG_W'(1);
        end
        n_wrap = n_deg;
        if (n_deg < 0) begin
            n_wrap = n_deg + FULL_TURN;
        end else if (n_deg >= FULL_TURN) begin
            n_wrap = n_deg - FULL_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bearing <= r_dzero2 ? 9'd0 : n_wrap[8:0];
    end

    assign busy              = 1'b0;
    assign o_valid           = r_vld[DEPTH-1];
    assign o_bearing_degrees = r_bearing;

    // checks
    `GCIB_ASSERT_IMP(a_bearing_range, i_clk, i_rst_n, o_valid, o_bearing_degrees < 9'd360, "bearing out of range")
    `GCIB_ASSERT_IMP(a_valid_origin, i_clk, i_rst_n, o_valid, $past(start, DEPTH), "result without a transfer")
    `GCIB_ASSERT_NXT(a_zero_vector, i_clk, i_rst_n, r_vld[IX_D2] && r_dzero2, o_bearing_degrees == 9'd0, "zero vector gave nonzero bearing")
    `GCIB_ASSERT_IMP(a_fold_range, i_clk, i_rst_n, r_vld[IX_W2], (r_rz[0][0] <= HALF_PI_Q30) && (r_rz[0][0] >= -HALF_PI_Q30) && (r_rz[0][2] <= HALF_PI_Q30) && (r_rz[0][2] >= -HALF_PI_Q30), "fold out of range")

endmodule

>>> dv/tb.sv
// Testbench for great_circle_initial_bearing: random and directed position pairs.
// Depends on gcib_pkg and the block RTL; bearings predicted by a local fixed-point model.
`timescale 1ns / 1ps

module tb
    import gcib_pkg::*;
();

    localparam int  NUM_RANDOM = 1100;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_CYCLES = 120;
    localparam longint PI_V = 64'sd3373259426;
    localparam longint HALF_PI_V = 64'sd1686629713;
    localparam longint INV_GAIN_V = 64'sd652032874;
    localparam longint LAT_MAX = 843314857;
    localparam longint LON_MAX = 1686629714;

    // floor shift of a signed value
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // reduce an angle into [-pi, pi)
    function automatic longint wrap_turn(longint a);
        longint r;
        r = a % (2 * PI_V);
        if (r >= PI_V) r -= 2 * PI_V;
        if (r < -PI_V) r += 2 * PI_V;
        return r;
    endfunction

    // rotation-mode CORDIC with quadrant folding
    function automatic void rotate_unit(input longint a, output longint s, output longint c);
        bit flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = INV_GAIN_V;
        y = 0;
        a = wrap_turn(a);
        if (a > HALF_PI_V) begin
            a -= PI_V;
            flip = 1;
        end else if (a < -HALF_PI_V) begin
            a += PI_V;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_q30(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_q30(i));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // vectoring-mode CORDIC angle of (x, y)
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI_V;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_V;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_q30(i));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q30(i));
            end
        end
        return z;
    endfunction

    function automatic logic [8:0] predict_bearing(logic signed [30:0] lat1,
            logic signed [31:0] lon1, logic signed [30:0] lat2, logic signed [31:0] lon2);
        longint a1, b1, a2, b2, s1, c1, s2, c2, sd, cd, y, x, t, ang, n, deg;
        a1 = longint'(lat1) * 2;
        b1 = longint'(lon1) * 2;
        a2 = longint'(lat2) * 2;
        b2 = longint'(lon2) * 2;
        rotate_unit(a1, s1, c1);
        rotate_unit(a2, s2, c2);
        rotate_unit(wrap_turn(b2 - b1), sd, cd);
        y = floor_shift(sd * c2, 30);
        t = floor_shift(s1 * c2, 30);
        x = floor_shift(c1 * s2, 30) - floor_shift(t * cd, 30);
        ang = vector_angle(y, x);
        n = ang * 180;
        deg = n / PI_V;
        if (n % PI_V != 0 && n < 0) deg -= 1;
        deg %= 360;
        if (deg < 0) deg += 360;
        return deg[8:0];
    endfunction

    class bearing_board;
        logic [8:0] pending[$];
        int errors;
        int shown;

        function void note_transfer(logic [8:0] want);
            pending.push_back(want);
        endfunction

        function void check_bearing(logic [8:0] got);
            logic [8:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected bearing %0d", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("bearing mismatch: expected %0d actual %0d", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [30:0] i_from_latitude;
    logic signed [31:0] i_from_longitude;
    logic signed [30:0] i_to_latitude;
    logic signed [31:0] i_to_longitude;
    logic o_valid;
    logic [8:0] o_bearing_degrees;

    bearing_board board;
    int cycle_count;

    great_circle_initial_bearing DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_from_latitude(i_from_latitude), .i_from_longitude(i_from_longitude),
        .i_to_latitude(i_to_latitude), .i_to_longitude(i_to_longitude),
        .o_valid(o_valid), .o_bearing_degrees(o_bearing_degrees)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // check results and watch the cycle budget
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) board.check_bearing(o_bearing_degrees);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("great_circle_initial_bearing regression: fail");
            $finish;
        end
    end

    function automatic longint pick(longint lim);
        longint r;
        r = longint'($urandom_range(0, 7));
        if (r == 0) return lim;
        if (r == 1) return -lim;
        if (r == 2) return longint'($urandom_range(0, 64)) - 32;
        return longint'({$urandom, $urandom}) % (lim + 1);
    endfunction

    // present one position pair and hold it until the transfer
    task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2);
        i_from_latitude = la1[30:0];
        i_from_longitude = lo1[31:0];
        i_to_latitude = la2[30:0];
        i_to_longitude = lo2[31:0];
        start = 1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        board.note_transfer(predict_bearing(i_from_latitude, i_from_longitude,
            i_to_latitude, i_to_longitude));
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start = 0;
        repeat (n) @(negedge i_clk);
    endtask

    initial begin
        int burst;
        board = new();
        cycle_count = 0;
        start = 0;
        i_rst_n = 0;
        i_from_latitude = 0;
        i_from_longitude = 0;
        i_to_latitude = 0;
        i_to_longitude = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // directed: identical points, poles, antimeridian, cardinal moves
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 0, 100000);
        send_pair(0, 0, 0, -100000);
        send_pair(0, 0, 100000, 0);
        send_pair(0, 0, -100000, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(-LAT_MAX, 0, LAT_MAX, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(100, 0, -100, -1);
        send_pair(-1, -1, -1, -1);
        send_pair(300000000, 5, 300000000, -5);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(0, 0, -1, 0);
        idle_cycles(3);

        // random bursts with gaps
        for (int k = 0; k < NUM_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && k < NUM_RANDOM; j++, k++)
                send_pair(pick(LAT_MAX), pick(LON_MAX), pick(LAT_MAX), pick(LON_MAX));
            if (k > NUM_RANDOM / 2 && k - burst <= NUM_RANDOM / 2) begin
                // drain the pipeline once before continuing
                start = 0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 12));
            end
        end

        start = 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.errors == 0)
            $display("great_circle_initial_bearing regression: pass");
        else
            $display("great_circle_initial_bearing regression: fail");
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/gcib_pkg.sv
design/great_circle_initial_bearing.sv
dv/tb.sv
